/* rtl/m4rm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4rm_pkg
// Types and constants shared by the 4x4 row multiply unit.
// ----------------------------------------------------------------------------
package m4rm_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned ROW_W  = 2;
  localparam int unsigned N_DIM  = 4;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // function codes of an input beat
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MUL  = 1'b1;

  typedef logic [N_DIM-1:0][ELEM_W-1:0] row_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef struct packed {
    logic              func;
    logic [ROW_W-1:0]  row;
    logic [ELEM_W-1:0] elem0;
    logic [ELEM_W-1:0] elem1;
    logic [ELEM_W-1:0] elem2;
    logic [ELEM_W-1:0] elem3;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [ELEM_W-1:0] res0;
    logic [ELEM_W-1:0] res1;
    logic [ELEM_W-1:0] res2;
    logic [ELEM_W-1:0] res3;
    logic              overflow;
  } out_t;

  // pipeline control carried alongside the lanes
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
  } ctl_t;

endpackage

/* rtl/m4rm_bstore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4rm_bstore
// Holds the right-hand matrix, written one row per load beat and presented
// column by column to the lanes.
// ----------------------------------------------------------------------------
module m4rm_bstore (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [m4rm_pkg::ROW_W-1:0]             wrow_i,
  input  m4rm_pkg::row_t                         wdata_i,
  output m4rm_pkg::row_t [m4rm_pkg::N_DIM-1:0]   col_o
);

  m4rm_pkg::row_t mem_q [m4rm_pkg::N_DIM];

  // contents are undefined until loaded, so no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wrow_i] <= wdata_i;
    end
  end

  // transpose: lane j sees column j, element k taken from row k
  always_comb begin
    for (int j = 0; j < m4rm_pkg::N_DIM; j++) begin
      for (int k = 0; k < m4rm_pkg::N_DIM; k++) begin
        col_o[j][k] = mem_q[k][j];
      end
    end
  end

endmodule

/* rtl/m4rm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4rm_lane
// One output column: four fixed-point products, scaled and summed exactly
// over three register stages.
// ----------------------------------------------------------------------------
module m4rm_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  m4rm_pkg::row_t  a_i,
  input  m4rm_pkg::row_t  b_i,
  output m4rm_pkg::sum_t  sum_o
);

  logic signed [m4rm_pkg::PROD_W-1:0] prod_d [m4rm_pkg::N_DIM];
  logic signed [m4rm_pkg::PROD_W-1:0] prod_q [m4rm_pkg::N_DIM];
  logic signed [m4rm_pkg::PROD_W-1:0] scl    [m4rm_pkg::N_DIM];
  logic signed [m4rm_pkg::PAIR_W-1:0] pair_d [2];
  logic signed [m4rm_pkg::PAIR_W-1:0] pair_q [2];
  m4rm_pkg::sum_t                     sum_d;
  m4rm_pkg::sum_t                     sum_q;

  always_comb begin
    for (int k = 0; k < m4rm_pkg::N_DIM; k++) begin
      prod_d[k] = $signed(a_i[k]) * $signed(b_i[k]);
      scl[k]    = prod_q[k] >>> FRAC_BITS;
    end
    pair_d[0] = m4rm_pkg::PAIR_W'(scl[0]) + m4rm_pkg::PAIR_W'(scl[1]);
    pair_d[1] = m4rm_pkg::PAIR_W'(scl[2]) + m4rm_pkg::PAIR_W'(scl[3]);
    sum_d     = m4rm_pkg::SUM_W'(pair_q[0]) + m4rm_pkg::SUM_W'(pair_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      pair_q <= pair_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/m4rm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4rm_merge
// Saturates the four lane sums, merges the overflow flags and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module m4rm_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  m4rm_pkg::ctl_t                        ctl_i,
  input  m4rm_pkg::sum_t [m4rm_pkg::N_DIM-1:0]  sum_i,
  output logic                                  valid_o,
  output m4rm_pkg::out_t                        out_o
);

  localparam int unsigned HI_W = m4rm_pkg::SUM_W - m4rm_pkg::ELEM_W + 1;

  logic [m4rm_pkg::ELEM_W-1:0] res [m4rm_pkg::N_DIM];
  logic [m4rm_pkg::N_DIM-1:0]  ovf;
  m4rm_pkg::out_t              out_d;
  m4rm_pkg::out_t              out_q;
  logic                        valid_q;

  always_comb begin
    for (int j = 0; j < m4rm_pkg::N_DIM; j++) begin
      // in range when all bits from bit 31 upward agree with the sign
      if (sum_i[j][m4rm_pkg::SUM_W-1 -: HI_W] == '0 ||
          sum_i[j][m4rm_pkg::SUM_W-1 -: HI_W] == '1) begin
        res[j] = sum_i[j][m4rm_pkg::ELEM_W-1:0];
        ovf[j] = 1'b0;
      end else if (sum_i[j][m4rm_pkg::SUM_W-1]) begin
        res[j] = {1'b1, {(m4rm_pkg::ELEM_W-1){1'b0}}};
        ovf[j] = 1'b1;
      end else begin
        res[j] = {1'b0, {(m4rm_pkg::ELEM_W-1){1'b1}}};
        ovf[j] = 1'b1;
      end
    end
    out_d.out_row  = ctl_i.row;
    out_d.res0     = res[0];
    out_d.res1     = res[1];
    out_d.res2     = res[2];
    out_d.res3     = res[3];
    out_d.overflow = |ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

/* rtl/matrix4_row_multiply_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_row_multiply_unit
// A multiply beat passes in order through multiply, pair add, final add and
// saturate into the output register before its result shows.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken. Load beats write B at acceptance and give
// no result. Reset clears the pipeline valid bits; B is not cleared.
// ----------------------------------------------------------------------------
module matrix4_row_multiply_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  m4rm_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output m4rm_pkg::out_t  out_o
);

  localparam int unsigned N_STG = 3;

  logic                                  en;
  logic                                  in_fire;
  m4rm_pkg::row_t                        a_row;
  m4rm_pkg::row_t [m4rm_pkg::N_DIM-1:0]  b_col;
  m4rm_pkg::sum_t [m4rm_pkg::N_DIM-1:0]  sums;
  m4rm_pkg::ctl_t                        ctl_d;
  m4rm_pkg::ctl_t                        ctl_q [N_STG];

  // advance everything when the output register is free or being drained
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  assign a_row = {in_i.elem3, in_i.elem2, in_i.elem1, in_i.elem0};

  always_comb begin
    ctl_d.valid = in_fire && (in_i.func == m4rm_pkg::FUNC_MUL);
    ctl_d.row   = in_i.row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N_STG; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_d;
      for (int s = 1; s < N_STG; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  m4rm_bstore u_bstore (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_i.func == m4rm_pkg::FUNC_LOAD)),
    .wrow_i  (in_i.row),
    .wdata_i (a_row),
    .col_o   (b_col)
  );

  for (genvar j = 0; j < m4rm_pkg::N_DIM; j++) begin : g_lane
    m4rm_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (a_row),
      .b_i   (b_col[j]),
      .sum_o (sums[j])
    );
  end

  m4rm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_q[N_STG-1]),
    .sum_i   (sums),
    .valid_o (out_valid_o),
    .out_o   (out_o)
  );

endmodule
